[rtl/frustum_box_classifier_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frustum box classifier
// Clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CLASSIFIER_ASSERT_SVH
`define FRUSTUM_BOX_CLASSIFIER_ASSERT_SVH

// antecedent and consequent checked at the same edge
`define FBC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked at the edge following the antecedent
`define FBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fbc_pkg.sv]
// ----------------------------------------------------------------------------
// fbc_pkg
// Widths, plane layout and verdict codes of the frustum box classifier.
// ----------------------------------------------------------------------------
package fbc_pkg;

   localparam int COORD_W      = 16;
   localparam int PLANE_W      = 64;
   localparam int PLANE_COUNT  = 6;
   localparam int CSR_INDEX_W  = 3;
   localparam int AXES         = 3;
   localparam int OFFSET_SHIFT = 14;
   // Q2.14 x Q12.4 product, exact
   localparam int PROD_W       = 2 * COORD_W;
   // three products plus the scaled offset
   localparam int SUM_W        = PROD_W + 2;

   localparam int NUM_PLANES_DEFAULT = PLANE_COUNT;

   typedef logic [1:0] verdict_type;

   localparam verdict_type VERDICT_INSIDE    = 2'd0;
   localparam verdict_type VERDICT_INTERSECT = 2'd1;
   localparam verdict_type VERDICT_OUTSIDE   = 2'd2;

   // plane register layout
   localparam int NX_LSB  = 0;
   localparam int NY_LSB  = 16;
   localparam int NZ_LSB  = 32;
   localparam int OFF_LSB = 48;

endpackage

[rtl/frustum_box_classifier.sv]
// ----------------------------------------------------------------------------
// frustum_box_classifier
// Classifies an axis-aligned box against up to six loaded frustum planes.
// ----------------------------------------------------------------------------
// A box is taken on every clock at which start is high; busy is never raised,
// so one box per cycle streams through. The verdict appears on rsp_verdict
// with rsp_valid high for one cycle, in the order the boxes came in; the
// receiver must take it then. The five stages are: input capture, the 16x16
// normal-by-coordinate multipliers (two per axis per plane), per-axis min/max
// selection, the per-plane distance add and sign test, and the verdict merge.
// For each plane the nearest and the farthest corner distance decide whether
// no, some or all corners lie behind it. Planes are to be written through the
// csr_ port only while the pipeline is empty, which the block does not enforce;
// csr_ready is always high and an index past the plane count is dropped.
module frustum_box_classifier
   #(
      parameter int NUM_PLANES = fbc_pkg::NUM_PLANES_DEFAULT
   )
   (
      input  logic                                clock,
      input  logic                                reset,

      input  logic                                start,
      output logic                                busy,
      input  logic signed [fbc_pkg::COORD_W-1:0]  req_min_x,
      input  logic signed [fbc_pkg::COORD_W-1:0]  req_min_y,
      input  logic signed [fbc_pkg::COORD_W-1:0]  req_min_z,
      input  logic signed [fbc_pkg::COORD_W-1:0]  req_max_x,
      input  logic signed [fbc_pkg::COORD_W-1:0]  req_max_y,
      input  logic signed [fbc_pkg::COORD_W-1:0]  req_max_z,

      output logic                                rsp_valid,
      output fbc_pkg::verdict_type                rsp_verdict,

      input  logic                                csr_valid,
      output logic                                csr_ready,
      input  logic [fbc_pkg::CSR_INDEX_W-1:0]     csr_index,
      input  logic [fbc_pkg::PLANE_W-1:0]         csr_data
   );

   import fbc_pkg::*;

   `include "frustum_box_classifier_assert.svh"

   // plane registers
   logic [PLANE_W-1:0] plane_ff [NUM_PLANES];
   logic [PLANE_W-1:0] plane_in [NUM_PLANES];

   // stage 1: captured box
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [COORD_W-1:0] box_lo_ff [AXES];
   logic signed [COORD_W-1:0] box_hi_ff [AXES];
   logic signed [COORD_W-1:0] box_lo_in [AXES];
   logic signed [COORD_W-1:0] box_hi_in [AXES];

   // stage 2: products
   logic                     s2_valid_ff, s2_valid_in;
   logic signed [PROD_W-1:0] prod_lo_ff [NUM_PLANES][AXES];
   logic signed [PROD_W-1:0] prod_hi_ff [NUM_PLANES][AXES];
   logic signed [PROD_W-1:0] prod_lo_in [NUM_PLANES][AXES];
   logic signed [PROD_W-1:0] prod_hi_in [NUM_PLANES][AXES];

   // stage 3: per-axis nearest and farthest terms
   logic                     s3_valid_ff, s3_valid_in;
   logic signed [PROD_W-1:0] term_min_ff [NUM_PLANES][AXES];
   logic signed [PROD_W-1:0] term_max_ff [NUM_PLANES][AXES];
   logic signed [PROD_W-1:0] term_min_in [NUM_PLANES][AXES];
   logic signed [PROD_W-1:0] term_max_in [NUM_PLANES][AXES];

   // stage 4: per-plane sign flags
   logic                  s4_valid_ff, s4_valid_in;
   logic [NUM_PLANES-1:0] any_neg_ff, any_neg_in;
   logic [NUM_PLANES-1:0] all_neg_ff, all_neg_in;

   // stage 5: result
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type verdict_ff, verdict_in;

   // ---------------------------------------------------------------- config
   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         plane_in[p] = plane_ff[p];
         if (csr_valid && csr_index == CSR_INDEX_W'(p)) begin
            plane_in[p] = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            plane_ff[p] <= '0;
         end
      end else begin
         plane_ff <= plane_in;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      box_lo_in[0] = req_min_x;
      box_lo_in[1] = req_min_y;
      box_lo_in[2] = req_min_z;
      box_hi_in[0] = req_max_x;
      box_hi_in[1] = req_max_y;
      box_hi_in[2] = req_max_z;
   end

   always_comb begin
      logic signed [COORD_W-1:0] nrm;
      nrm = '0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int a = 0; a < AXES; a++) begin
            nrm = plane_ff[p][a*COORD_W +: COORD_W];
            prod_lo_in[p][a] = PROD_W'(nrm * box_lo_ff[a]);
            prod_hi_in[p][a] = PROD_W'(nrm * box_hi_ff[a]);
         end
      end
   end

   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int a = 0; a < AXES; a++) begin
            if (prod_lo_ff[p][a] < prod_hi_ff[p][a]) begin
               term_min_in[p][a] = prod_lo_ff[p][a];
               term_max_in[p][a] = prod_hi_ff[p][a];
            end else begin
               term_min_in[p][a] = prod_hi_ff[p][a];
               term_max_in[p][a] = prod_lo_ff[p][a];
            end
         end
      end
   end

   always_comb begin
      logic signed [COORD_W-1:0] off;
      logic signed [SUM_W-1:0]   off_scaled;
      logic signed [SUM_W-1:0]   dist_min;
      logic signed [SUM_W-1:0]   dist_max;
      off        = '0;
      off_scaled = '0;
      dist_min   = '0;
      dist_max   = '0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         off        = plane_ff[p][OFF_LSB +: COORD_W];
         off_scaled = SUM_W'($signed({off, {OFFSET_SHIFT{1'b0}}}));
         dist_min   = SUM_W'(term_min_ff[p][0]) + SUM_W'(term_min_ff[p][1])
                    + SUM_W'(term_min_ff[p][2]) + off_scaled;
         dist_max   = SUM_W'(term_max_ff[p][0]) + SUM_W'(term_max_ff[p][1])
                    + SUM_W'(term_max_ff[p][2]) + off_scaled;
         // nearest corner behind: some corners out; farthest behind: all out
         any_neg_in[p] = dist_min[SUM_W-1];
         all_neg_in[p] = dist_max[SUM_W-1];
      end
   end

   always_comb begin
      priority if (|all_neg_ff) begin
         verdict_in = VERDICT_OUTSIDE;
      end else if (|any_neg_ff) begin
         verdict_in = VERDICT_INTERSECT;
      end else begin
         verdict_in = VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      box_lo_ff   <= box_lo_in;
      box_hi_ff   <= box_hi_in;
      prod_lo_ff  <= prod_lo_in;
      prod_hi_ff  <= prod_hi_in;
      term_min_ff <= term_min_in;
      term_max_ff <= term_max_in;
      any_neg_ff  <= any_neg_in;
      all_neg_ff  <= all_neg_in;
      verdict_ff  <= verdict_in;
   end

   // ---------------------------------------------------------------- valids
   assign s1_valid_in  = start && !busy;
   assign s2_valid_in  = s1_valid_ff;
   assign s3_valid_in  = s2_valid_ff;
   assign s4_valid_in  = s3_valid_ff;
   assign rsp_valid_in = s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy        = 1'b0;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

   // ---------------------------------------------------------------- checks
   // every accepted box yields a verdict beat
   `FBC_ASSERT_NEXT(a_latency, start && !busy, ##4 rsp_valid, "verdict beat missing")
   // a plane with every corner behind it must also have its nearest corner behind
   `FBC_ASSERT_SAME(a_flags, s4_valid_ff, (all_neg_ff & ~any_neg_ff) == '0, "min/max swapped")
   // outside verdict only when some plane rejected all corners
   `FBC_ASSERT_NEXT(a_outside, s4_valid_ff, (rsp_verdict == VERDICT_OUTSIDE) == $past(|all_neg_ff), "outside mismatch")

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: frustum box classifier testbench
// Loads sets of six planes through the csr_ port, then streams boxes in
// bursts. Each accepted box is classified by a local predictor and its
// verdict queued. Each verdict is checked in order against that queue.
// Covers the reset (all-zero) planes, exact and skewed frustums, random and
// extreme plane words, and writes to the unused register indexes.
// ----------------------------------------------------------------------------
module tb;
   import fbc_pkg::*;

   localparam int NUM_PLANES = PLANE_COUNT;
   localparam int CORNERS    = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      PLANE_TOP, PLANE_BOTTOM, PLANE_LEFT, PLANE_RIGHT, PLANE_NEAR, PLANE_FAR,
      PLANE_SPARE_A, PLANE_SPARE_B
   } plane_index_type;

   typedef struct {
      logic signed [COORD_W-1:0] lo [AXES];
      logic signed [COORD_W-1:0] hi [AXES];
   } box_type;

   class verdict_scoreboard;
      logic [PLANE_W-1:0] planes [PLANE_COUNT];
      verdict_type        awaited [$];
      int unsigned        errors;

      function new();
         foreach (planes[i]) planes[i] = '0;
         errors = 0;
      endfunction

      function void load_plane(plane_index_type idx, logic [PLANE_W-1:0] val);
         if (idx < PLANE_COUNT) planes[idx] = val;
      endfunction

      function verdict_type classify(box_type b);
         longint     nrm [AXES];
         longint     crn [AXES];
         longint     off;
         longint     distance;
         int         behind;
         verdict_type v;
         v = VERDICT_INSIDE;
         for (int p = 0; p < NUM_PLANES; p++) begin
            nrm[0] = longint'($signed(planes[p][NX_LSB +: COORD_W]));
            nrm[1] = longint'($signed(planes[p][NY_LSB +: COORD_W]));
            nrm[2] = longint'($signed(planes[p][NZ_LSB +: COORD_W]));
            off    = longint'($signed(planes[p][OFF_LSB +: COORD_W]));
            behind = 0;
            for (int k = 0; k < CORNERS; k++) begin
               for (int a = 0; a < AXES; a++)
                  crn[a] = k[a] ? longint'(b.hi[a]) : longint'(b.lo[a]);
               distance = nrm[0] * crn[0] + nrm[1] * crn[1] + nrm[2] * crn[2]
                          + (off <<< OFFSET_SHIFT);
               // on the plane counts as inside
               if (distance < 0) behind++;
            end
            if (behind == CORNERS)
               v = VERDICT_OUTSIDE;
            else if (behind > 0 && v == VERDICT_INSIDE)
               v = VERDICT_INTERSECT;
         end
         return v;
      endfunction

      function void note_box(box_type b);
         awaited.push_back(classify(b));
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (awaited.size() == 0) begin
            $display("%0t: verdict %0d with none expected", $time, got);
            errors++;
         end else begin
            want = awaited.pop_front();
            if (got !== want) begin
               $display("%0t: verdict mismatch, expected %0d, got %0d", $time, want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [COORD_W-1:0] req_min_x, req_min_y, req_min_z;
   logic signed [COORD_W-1:0] req_max_x, req_max_y, req_max_z;
   logic                      rsp_valid;
   verdict_type               rsp_verdict;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [PLANE_W-1:0]        csr_data;

   verdict_scoreboard sb;

   frustum_box_classifier #(.NUM_PLANES(NUM_PLANES)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_min_x   (req_min_x),
      .req_min_y   (req_min_y),
      .req_min_z   (req_min_z),
      .req_max_x   (req_max_x),
      .req_max_y   (req_max_y),
      .req_max_z   (req_max_z),
      .rsp_valid   (rsp_valid),
      .rsp_verdict (rsp_verdict),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // monitor: box beats in, verdict beats out
   always @(posedge clock) begin : monitor
      box_type seen;
      if (!reset) begin
         if (start && !busy) begin
            seen.lo[0] = req_min_x; seen.lo[1] = req_min_y; seen.lo[2] = req_min_z;
            seen.hi[0] = req_max_x; seen.hi[1] = req_max_y; seen.hi[2] = req_max_z;
            sb.note_box(seen);
         end
         if (rsp_valid) sb.check_verdict(rsp_verdict);
      end
   end

   function automatic logic signed [COORD_W-1:0] clamp16(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return COORD_W'(v);
   endfunction

   function automatic box_type make_box(int lx, int ly, int lz, int hx, int hy, int hz);
      box_type b;
      b.lo[0] = clamp16(lx); b.lo[1] = clamp16(ly); b.lo[2] = clamp16(lz);
      b.hi[0] = clamp16(hx); b.hi[1] = clamp16(hy); b.hi[2] = clamp16(hz);
      return b;
   endfunction

   function automatic box_type random_box(int span);
      box_type                   b;
      int                        centre;
      int                        half;
      int                        mode;
      logic signed [COORD_W-1:0] t;
      mode = $urandom_range(0, 9);
      for (int a = 0; a < AXES; a++) begin
         if (mode == 0) begin
            b.lo[a] = COORD_W'($urandom);
            b.hi[a] = COORD_W'($urandom);
         end else begin
            centre = int'($urandom_range(0, 2 * span)) - span;
            half   = (mode == 1) ? 0 : int'($urandom_range(0, span / 4 + 1));
            b.lo[a] = clamp16(centre - half);
            b.hi[a] = clamp16(centre + half);
            // reversed corners now and then
            if (mode == 9) begin
               t = b.lo[a]; b.lo[a] = b.hi[a]; b.hi[a] = t;
            end
         end
      end
      return b;
   endfunction

   function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
      return {COORD_W'(d), COORD_W'(nz), COORD_W'(ny), COORD_W'(nx)};
   endfunction

   function automatic int jitter(int j);
      return int'($urandom_range(0, 2 * j)) - j;
   endfunction

   task automatic send_box(box_type b);
      @(negedge clock);
      start     <= 1'b1;
      req_min_x <= b.lo[0]; req_min_y <= b.lo[1]; req_min_z <= b.lo[2];
      req_max_x <= b.hi[0]; req_max_y <= b.hi[1]; req_max_z <= b.hi[2];
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop sending and let every queued verdict come back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic write_plane(plane_index_type idx, logic [PLANE_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.load_plane(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // inward planes of an axis-aligned cube of half extents ax, ay, az
   task automatic load_cube(int ax, int ay, int az, int j);
      write_plane(PLANE_TOP,    pack_plane(jitter(j), -16384 + jitter(j), jitter(j), ay));
      write_plane(PLANE_BOTTOM, pack_plane(jitter(j),  16384 + jitter(j), jitter(j), ay));
      write_plane(PLANE_LEFT,   pack_plane( 16384 + jitter(j), jitter(j), jitter(j), ax));
      write_plane(PLANE_RIGHT,  pack_plane(-16384 + jitter(j), jitter(j), jitter(j), ax));
      write_plane(PLANE_NEAR,   pack_plane(jitter(j), jitter(j),  16384 + jitter(j), az));
      write_plane(PLANE_FAR,    pack_plane(jitter(j), jitter(j), -16384 + jitter(j), az));
   endtask

   task automatic run_boxes(int count, int span);
      int left;
      int burst;
      int gap;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && left > 0; i++) begin
            send_box(random_box(span));
            left--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      drain();
   endtask

   initial begin
      #2_000_000;
      $display("[frustum_box_classifier] ERROR");
      $finish;
   end

   initial begin
      int a;
      sb        = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_min_x = '0; req_min_y = '0; req_min_z = '0;
      req_max_x = '0; req_max_y = '0; req_max_z = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // planes at reset: everything is inside
      send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
      send_box(make_box(500, 500, 500, -500, -500, -500));
      drain();

      // exact cube of half extent 100.0
      load_cube(1600, 1600, 1600, 0);
      send_box(make_box(0, 0, 0, 0, 0, 0));
      send_box(make_box(-1600, -10, -10, -1500, 10, 10));
      send_box(make_box(-1600, -1600, -1600, 1600, 1600, 1600));
      send_box(make_box(-1601, 0, 0, 0, 0, 0));
      send_box(make_box(-3000, -3000, -3000, -2000, -2000, -2000));
      send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
      send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
      send_box(make_box(100, 100, 100, -100, -100, -100));
      send_box(make_box(2000, 0, 0, -100, 0, 0));
      send_box(make_box(1600, 1600, 1600, 1600, 1600, 1600));
      send_box(make_box(1601, 0, 0, 1601, 0, 0));
      send_box(make_box(0, 0, 1000, 0, 0, 5000));
      send_box(make_box(21845, -21846, 21845, -21846, 21845, -21846));
      drain();

      a = $urandom_range(16, 16000);
      load_cube(a, $urandom_range(16, 16000), $urandom_range(16, 16000), 0);
      run_boxes(120, 2 * a);

      a = $urandom_range(200, 12000);
      load_cube(a, a, $urandom_range(200, 12000), 3000);
      run_boxes(130, 2 * a);

      // unused indexes must be dropped
      write_plane(PLANE_SPARE_A, {$urandom, $urandom});
      write_plane(PLANE_SPARE_B, {$urandom, $urandom});
      for (int p = 0; p < PLANE_COUNT; p++)
         write_plane(plane_index_type'(p), {$urandom, $urandom});
      run_boxes(130, 32767);

      write_plane(PLANE_TOP,    64'h8000_8000_8000_8000);
      write_plane(PLANE_BOTTOM, 64'h7FFF_7FFF_7FFF_7FFF);
      write_plane(PLANE_LEFT,   64'hFFFF_FFFF_FFFF_FFFF);
      write_plane(PLANE_RIGHT,  64'h0000_0000_0000_0000);
      write_plane(PLANE_NEAR,   64'h0001_0001_0001_0001);
      write_plane(PLANE_FAR,    64'h7FFF_8000_7FFF_8000);
      run_boxes(80, 32767);

      // one live plane, the rest zero
      for (int p = 0; p < PLANE_COUNT; p++)
         write_plane(plane_index_type'(p), '0);
      write_plane(plane_index_type'($urandom_range(0, PLANE_COUNT - 1)),
                  pack_plane(jitter(20000), jitter(20000), jitter(20000), jitter(20000)));
      run_boxes(130, 8000);

      a = $urandom_range(16, 4000);
      load_cube(a, a, a, 400);
      run_boxes(140, 2 * a);

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("[frustum_box_classifier] OK");
      else
         $display("[frustum_box_classifier] ERROR");
      $finish;
   end
endmodule
